>>> design/pfi_pkg.sv
// package for the palette fade interpolator
// types, codes and constants shared by the front, queue, back and top level
// no dependencies
package pfi_pkg;

	// palette geometry and field widths
	localparam int ENTRIES     = 16;
	localparam int IDX_W       = 4;
	localparam int COLOR_W     = 15;
	localparam int DUR_W       = 16;
	localparam int CLK_W       = 17;
	localparam int CHANNELS    = 3;
	localparam int PROD_W      = 31;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// divider retires this many quotient bits per cycle
	localparam int DIV_BITS    = 2;
	localparam int DIV_CYCLES  = DUR_W / DIV_BITS;
	localparam int DCNT_W      = $clog2(DIV_CYCLES);

	// channel fields of an rgb555 color, kept in place
	localparam logic [COLOR_W-1:0] RED_MASK   = 15'h001F;
	localparam logic [COLOR_W-1:0] GREEN_MASK = 15'h03E0;
	localparam logic [COLOR_W-1:0] BLUE_MASK  = 15'h7C00;

	// input function codes
	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_START = 2'd1,
		FUNC_TICK  = 2'd2
	} func_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_DURATION   = 2'd0,
		REG_EARLY_STOP = 2'd1,
		REG_STOP_STEP  = 2'd2
	} reg_idx_t;

	// commands passed from front to back
	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_DONE   = 2'd1,
		CMD_COLORS = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t            kind;
		logic [IDX_W-1:0]     idx;
		logic [COLOR_W-1:0]   start_color;
		logic [COLOR_W-1:0]   target_color;
		logic [CLK_W-1:0]     clock;
	} cmd_t;

	typedef struct packed {
		logic [DUR_W-1:0] duration;
		logic             early_stop_enable;
		logic [DUR_W-1:0] stop_step;
	} cfg_t;

	// back-end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_EMIT
	} back_state_t;

	// channel mask by channel number
	function automatic logic [COLOR_W-1:0] chan_mask(input logic [1:0] chan);
		logic [COLOR_W-1:0] m;
		case (chan)
			2'd0:    m = RED_MASK;
			2'd1:    m = GREEN_MASK;
			2'd2:    m = BLUE_MASK;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

>>> design/pfi_front.sv
// front end: accepts input words, owns the step clock, classifies ticks
// depends on pfi_pkg
module pfi_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    func,
	input  logic [pfi_pkg::IDX_W-1:0]     entry_index,
	input  logic [pfi_pkg::COLOR_W-1:0]   start_color,
	input  logic [pfi_pkg::COLOR_W-1:0]   target_color,
	input  pfi_pkg::cfg_t                 cfg,
	input  logic                          q_full,
	output logic                          push,
	output pfi_pkg::cmd_t                 push_cmd
);
	import pfi_pkg::*;

	logic [CLK_W-1:0] clock_q;
	logic [CLK_W-1:0] stop;
	logic             accept;
	logic             tick_done;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// stop point and done test
	assign stop      = cfg.early_stop_enable ? {1'b0, cfg.stop_step}
	                                         : {1'b0, cfg.duration} + 17'd1;
	assign tick_done = (clock_q == stop) || (clock_q > {1'b0, cfg.duration});

	// classify the word into a back-end command
	always_comb begin
		push                  = 1'b0;
		push_cmd.kind         = CMD_LOAD;
		push_cmd.idx          = entry_index;
		push_cmd.start_color  = start_color;
		push_cmd.target_color = target_color;
		push_cmd.clock        = clock_q;
		case (func)
			FUNC_LOAD: begin
				push = accept && (32'(entry_index) < ENTRIES);
			end
			FUNC_TICK: begin
				push          = accept;
				push_cmd.kind = tick_done ? CMD_DONE : CMD_COLORS;
			end
			default: ;
		endcase
	end

	// step clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
		end else if (accept && func == FUNC_START) begin
			clock_q <= '0;
		end else if (accept && func == FUNC_TICK && !tick_done) begin
			clock_q <= clock_q + 17'd1;
		end
	end

endmodule

>>> design/pfi_queue.sv
// short command queue between front and back
// depends on pfi_pkg
module pfi_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pfi_pkg::cmd_t push_cmd,
	output logic          full,
	output logic          not_empty,
	input  logic          pop,
	output pfi_pkg::cmd_t head
);
	import pfi_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

>>> design/pfi_back.sv
// back end: palette store, blend sequencer with shared multiplier and
// radix-4 divider, and the output register; depends on pfi_pkg
module pfi_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pfi_pkg::cfg_t                 cfg,
	input  logic                          q_valid,
	input  pfi_pkg::cmd_t                 q_head,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pfi_pkg::IDX_W-1:0]     color_index,
	output logic [pfi_pkg::COLOR_W-1:0]   blended_color,
	output logic                          fade_done,
	output logic                          last
);
	import pfi_pkg::*;

	back_state_t         state_q, state_d;
	logic [COLOR_W-1:0]  start_mem  [ENTRIES];
	logic [COLOR_W-1:0]  target_mem [ENTRIES];
	logic [COLOR_W-1:0]  rd_start_q, rd_target_q;
	logic [DUR_W-1:0]    clock_q;
	logic [IDX_W-1:0]    entry_q;
	logic [1:0]          chan_q;
	logic [DCNT_W-1:0]   div_cnt_q;
	logic                neg_q;
	logic [DUR_W-1:0]    rem_q;
	logic [DUR_W-1:0]    quo_q;
	logic [COLOR_W-1:0]  color_q;
	logic                out_valid_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic [COLOR_W-1:0]  out_color_q;
	logic                out_done_q;
	logic                out_last_q;

	logic                out_free;
	logic                load_done;
	logic                load_color;
	logic                entry_last;
	logic [COLOR_W-1:0]  mask;
	logic [COLOR_W-1:0]  ch_a, ch_b, mag, quo_trim, ch_res;
	logic [PROD_W-1:0]   prod;
	logic [DUR_W-1:0]    rem_d, quo_d;

	assign out_free   = !out_valid_q || !out_stall;
	assign entry_last = (entry_q == IDX_W'(ENTRIES-1));

	// channel operands in place
	assign mask = chan_mask(chan_q);
	assign ch_a = rd_start_q & mask;
	assign ch_b = rd_target_q & mask;
	assign mag  = (ch_b >= ch_a) ? ch_b - ch_a : ch_a - ch_b;
	assign prod = PROD_W'(mag) * PROD_W'(clock_q);

	// two restoring division steps per cycle
	always_comb begin
		logic [DUR_W:0]   r;
		logic [DUR_W-1:0] d;
		r = {1'b0, rem_q};
		d = quo_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			r = {r[DUR_W-1:0], d[DUR_W-1]};
			d = {d[DUR_W-2:0], 1'b0};
			if (r >= {1'b0, cfg.duration}) begin
				r    = r - {1'b0, cfg.duration};
				d[0] = 1'b1;
			end
		end
		rem_d = r[DUR_W-1:0];
		quo_d = d;
	end

	// channel result; quotient never exceeds the channel difference
	assign quo_trim = quo_q[COLOR_W-1:0];
	always_comb begin
		if (cfg.duration == '0) begin
			ch_res = ch_b;
		end else if (neg_q) begin
			ch_res = (ch_a - quo_trim) & mask;
		end else begin
			ch_res = (ch_a + quo_trim) & mask;
		end
	end

	// sequencer next state
	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		load_done  = 1'b0;
		load_color = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_head.kind)
						CMD_LOAD: begin
							q_pop = 1'b1;
						end
						CMD_DONE: begin
							q_pop     = out_free;
							load_done = out_free;
						end
						CMD_COLORS: begin
							q_pop   = 1'b1;
							state_d = ST_READ;
						end
						default: begin
							q_pop = 1'b1;
						end
					endcase
				end
			end
			ST_READ: state_d = ST_MUL;
			ST_MUL:  state_d = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == DCNT_W'(DIV_CYCLES-1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = (chan_q == 2'(CHANNELS-1)) ? ST_EMIT : ST_MUL;
			end
			ST_EMIT: begin
				if (out_free) begin
					load_color = 1'b1;
					state_d    = entry_last ? ST_IDLE : ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			entry_q     <= '0;
			chan_q      <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop && q_head.kind == CMD_COLORS) begin
				entry_q <= '0;
			end else if (load_color) begin
				entry_q <= entry_q + 1'b1;
			end
			if (state_q == ST_READ) begin
				chan_q <= '0;
			end else if (state_q == ST_FIN) begin
				chan_q <= chan_q + 1'b1;
			end
			if (state_q == ST_MUL) begin
				div_cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (load_done || load_color) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// palette store
	always_ff @(posedge clk) begin
		if (q_pop && q_head.kind == CMD_LOAD) begin
			start_mem[q_head.idx]  <= q_head.start_color;
			target_mem[q_head.idx] <= q_head.target_color;
		end
		if (state_q == ST_READ) begin
			rd_start_q  <= start_mem[entry_q];
			rd_target_q <= target_mem[entry_q];
		end
	end

	// blend datapath
	always_ff @(posedge clk) begin
		if (q_pop && q_head.kind == CMD_COLORS) begin
			clock_q <= q_head.clock[DUR_W-1:0];
		end
		case (state_q)
			ST_READ: begin
				color_q <= '0;
			end
			ST_MUL: begin
				neg_q <= (ch_b < ch_a);
				rem_q <= {1'b0, prod[PROD_W-1:DUR_W]};
				quo_q <= prod[DUR_W-1:0];
			end
			ST_DIV: begin
				rem_q <= rem_d;
				quo_q <= quo_d;
			end
			ST_FIN: begin
				color_q <= color_q | ch_res;
			end
			default: ;
		endcase
	end

	// output word register
	always_ff @(posedge clk) begin
		if (load_done) begin
			out_idx_q   <= '0;
			out_color_q <= '0;
			out_done_q  <= 1'b1;
			out_last_q  <= 1'b1;
		end else if (load_color) begin
			out_idx_q   <= entry_q;
			out_color_q <= color_q;
			out_done_q  <= 1'b0;
			out_last_q  <= entry_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign color_index   = out_idx_q;
	assign blended_color = out_color_q;
	assign fade_done     = out_done_q;
	assign last          = out_last_q;

endmodule

>>> design/palette_fade_interpolator.sv
// rgb555 palette fade: a color tick makes the back end, for each of the 16 entries,
// read the entry, then per channel multiply, run the radix-4 divider and
// accumulate, then emit the output word; a done tick emits a single done word
// the two-entry queue lets the front keep accepting while the back works
// reset clears the step clock, queue and sequencer, config takes its defaults
module palette_fade_interpolator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [pfi_pkg::DUR_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    func,
	input  logic [pfi_pkg::IDX_W-1:0]     entry_index,
	input  logic [pfi_pkg::COLOR_W-1:0]   start_color,
	input  logic [pfi_pkg::COLOR_W-1:0]   target_color,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pfi_pkg::IDX_W-1:0]     color_index,
	output logic [pfi_pkg::COLOR_W-1:0]   blended_color,
	output logic                          fade_done,
	output logic                          last
);
	import pfi_pkg::*;

	cfg_t cfg_q;
	logic q_full, q_not_empty, q_push, q_pop;
	cmd_t push_cmd, q_head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duration          <= 16'd16;
			cfg_q.early_stop_enable <= 1'b0;
			cfg_q.stop_step         <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DURATION:   cfg_q.duration          <= cfg_data;
				REG_EARLY_STOP: cfg_q.early_stop_enable <= cfg_data[0];
				REG_STOP_STEP:  cfg_q.stop_step         <= cfg_data;
				default: ;
			endcase
		end
	end

	pfi_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.entry_index  (entry_index),
		.start_color  (start_color),
		.target_color (target_color),
		.cfg          (cfg_q),
		.q_full       (q_full),
		.push         (q_push),
		.push_cmd     (push_cmd)
	);

	pfi_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.head      (q_head)
	);

	pfi_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_not_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.color_index   (color_index),
		.blended_color (blended_color),
		.fade_done     (fade_done),
		.last          (last)
	);

endmodule

>>> design/pfi_checker.sv
// port-level checks for the palette fade interpolator, bound to the top level
// depends on pfi_pkg
module pfi_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [pfi_pkg::IDX_W-1:0]     color_index,
	input logic [pfi_pkg::COLOR_W-1:0]   blended_color,
	input logic                          fade_done,
	input logic                          last
);
	import pfi_pkg::*;

	// a done word closes its tick
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fade_done |-> last)
		else $error("done word without last");

	// a done word carries no color
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fade_done |-> color_index == '0 && blended_color == '0)
		else $error("done word carries color data");

	// the last color word of a tick belongs to the final entry
	a_last_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last && !fade_done |-> color_index == IDX_W'(ENTRIES-1))
		else $error("tick closed on wrong entry");

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(blended_color)
			&& $stable(color_index) && $stable(last) && $stable(fade_done))
		else $error("stalled output word changed");

endmodule

bind palette_fade_interpolator pfi_checker u_pfi_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.color_index   (color_index),
	.blended_color (blended_color),
	.fade_done     (fade_done),
	.last          (last)
);

>>> sim/palette_fade_interpolator_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for palette_fade_interpolator: load, start and tick words
// with random idling, a blended color predictor and an in-order result scoreboard
// depends on pfi_pkg and the design sources of palette_fade_interpolator
module palette_fade_interpolator_tb;
	import pfi_pkg::*;

	// func value that the block must ignore
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int IDLE_PCT        = 27;
	localparam int HOLD_CYCLES     = 2500;
	localparam int SETTLE_CYCLES   = 600;
	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int PHASES          = 8;
	localparam int WORDS_PER_PHASE = 17;

	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		logic [COLOR_W-1:0] color;
		logic               done;
		logic               last_word;
	} blend_word_t;

	// predicts the fade and checks result words in order
	class fade_scoreboard;
		localparam int MAX_PRINTED = 40;
		logic [COLOR_W-1:0] start_pal [ENTRIES];
		logic [COLOR_W-1:0] target_pal [ENTRIES];
		logic [CLK_W-1:0]   step_clock;
		logic [DUR_W-1:0]   duration;
		logic               early_stop;
		logic [DUR_W-1:0]   stop_step;
		blend_word_t        expected_words [$];
		int errors, words_in, words_checked, color_ticks, done_ticks;

		function new();
			step_clock = '0;
			duration   = 16'd16;
			early_stop = 1'b0;
			stop_step  = '0;
			errors = 0; words_in = 0; words_checked = 0; color_ticks = 0; done_ticks = 0;
		endfunction

		function void write_reg(reg_idx_t r, logic [DUR_W-1:0] v);
			case (r)
				REG_DURATION:   duration = v;
				REG_EARLY_STOP: early_stop = v[0];
				REG_STOP_STEP:  stop_step = v;
				default: ;
			endcase
		endfunction

		// one channel in place: a + (b - a) * clock / duration, truncating
		function logic [COLOR_W-1:0] blend_channel(logic [COLOR_W-1:0] a,
				logic [COLOR_W-1:0] b, logic [COLOR_W-1:0] mask);
			longint ca, cb, r;
			ca = longint'(a & mask);
			cb = longint'(b & mask);
			if (duration == '0)
				return b & mask;
			r = ca + ((cb - ca) * longint'(step_clock)) / longint'(duration);
			return COLOR_W'(r) & mask;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("mismatch at %0t ns: %s", $time, msg);
		endtask

		// accepted input word: update state and queue the words it causes
		task take_input(logic [1:0] f, logic [IDX_W-1:0] idx,
				logic [COLOR_W-1:0] sc, logic [COLOR_W-1:0] tc);
			blend_word_t w;
			logic [CLK_W-1:0] stop_at;
			words_in++;
			case (f)
				FUNC_LOAD: begin
					start_pal[idx]  = sc;
					target_pal[idx] = tc;
				end
				FUNC_START: step_clock = '0;
				FUNC_TICK: begin
					stop_at = early_stop ? CLK_W'(stop_step) : CLK_W'(duration) + 1'b1;
					if (step_clock == stop_at || step_clock > CLK_W'(duration)) begin
						w.idx = '0;
						w.color = '0;
						w.done = 1'b1;
						w.last_word = 1'b1;
						expected_words.push_back(w);
						done_ticks++;
					end else begin
						for (int e = 0; e < ENTRIES; e++) begin
							w.idx = IDX_W'(e);
							w.color = blend_channel(start_pal[e], target_pal[e], BLUE_MASK)
								| blend_channel(start_pal[e], target_pal[e], GREEN_MASK)
								| blend_channel(start_pal[e], target_pal[e], RED_MASK);
							w.done = 1'b0;
							w.last_word = (e == ENTRIES - 1);
							expected_words.push_back(w);
						end
						step_clock = step_clock + 1'b1;
						color_ticks++;
					end
				end
				default: ;
			endcase
		endtask

		// accepted result word against the oldest expectation
		task check_output(logic [IDX_W-1:0] idx, logic [COLOR_W-1:0] color,
				logic done, logic lst);
			blend_word_t w;
			if (expected_words.size() == 0) begin
				report($sformatf("unexpected word: index %0d color %h done %b last %b",
					idx, color, done, lst));
				return;
			end
			w = expected_words.pop_front();
			words_checked++;
			if (idx !== w.idx)
				report($sformatf("color_index %0d, expected %0d", idx, w.idx));
			if (color !== w.color)
				report($sformatf("blended_color %h, expected %h (entry %0d)",
					color, w.color, w.idx));
			if (done !== w.done)
				report($sformatf("fade_done %b, expected %b", done, w.done));
			if (lst !== w.last_word)
				report($sformatf("last %b, expected %b (entry %0d)", lst, w.last_word, w.idx));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [DUR_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          func;
	logic [IDX_W-1:0]    entry_index;
	logic [COLOR_W-1:0]  start_color;
	logic [COLOR_W-1:0]  target_color;
	logic                out_valid;
	logic                out_stall;
	logic [IDX_W-1:0]    color_index;
	logic [COLOR_W-1:0]  blended_color;
	logic                fade_done;
	logic                last;

	fade_scoreboard board = new();
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	int holds_done = 0;
	int quiet_cycles = 0;

	palette_fade_interpolator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.entry_index   (entry_index),
		.start_color   (start_color),
		.target_color  (target_color),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.color_index   (color_index),
		.blended_color (blended_color),
		.fade_done     (fade_done),
		.last          (last)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// note accepted input words, check accepted result words
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			board.take_input(func, entry_index, start_color, target_color);
		if (arst_n && out_valid && !out_stall)
			board.check_output(color_index, blended_color, fade_done, last);
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_done++;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	function automatic logic [COLOR_W-1:0] pick_color();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return COLOR_W'($urandom);
		endcase
	endfunction

	// offer one word, idling at random first, and wait for acceptance
	task automatic send_word(input logic [1:0] f, input logic [IDX_W-1:0] idx,
			input logic [COLOR_W-1:0] sc, input logic [COLOR_W-1:0] tc);
		@(negedge clk);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		func         <= f;
		entry_index  <= idx;
		start_color  <= sc;
		target_color <= tc;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// tick, start or unused func with random don't-care fields
	task automatic send_plain(input logic [1:0] f);
		send_word(f, IDX_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
	endtask

	// wait for every expected word, then let trailing loads and starts finish
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.expected_words.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// write all three registers while the block is idle
	task automatic set_fade(input logic [DUR_W-1:0] dur, input logic early,
			input logic [DUR_W-1:0] stop);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DURATION;
		cfg_data  <= dur;
		@(negedge clk);
		cfg_index <= REG_EARLY_STOP;
		cfg_data  <= {(DUR_W-1)'($urandom), early};
		@(negedge clk);
		cfg_index <= REG_STOP_STEP;
		cfg_data  <= stop;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.write_reg(REG_DURATION, dur);
		board.write_reg(REG_EARLY_STOP, {{(DUR_W-1){1'b0}}, early});
		board.write_reg(REG_STOP_STEP, stop);
	endtask

	// stimulus
	initial begin
		int p, n, pick, dur, stop;
		bit early;
		logic [COLOR_W-1:0] sc, tc;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_DURATION;
		cfg_data     = '0;
		in_valid     = 1'b0;
		func         = FUNC_LOAD;
		entry_index  = '0;
		start_color  = '0;
		target_color = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: fill the whole palette, the first entries with fixed extremes and patterns
		set_fade(16'd2, 1'b0, 16'd0);
		for (int e = 0; e < ENTRIES; e++) begin
			case (e)
				0:       begin sc = '0;         tc = '1;         end
				1:       begin sc = '1;         tc = '0;         end
				2:       begin sc = RED_MASK;   tc = '0;         end
				3:       begin sc = GREEN_MASK; tc = BLUE_MASK;  end
				4:       begin sc = BLUE_MASK;  tc = RED_MASK;   end
				5:       begin sc = 15'h5555;   tc = 15'h5555;   end
				6:       begin sc = 15'h2AAA;   tc = 15'h5555;   end
				7:       begin sc = '0;         tc = GREEN_MASK; end
				default: begin sc = pick_color(); tc = pick_color(); end
			endcase
			send_word(FUNC_LOAD, IDX_W'(e), sc, tc);
		end
		// ignored func, then a short fade that runs to its end and stays done
		send_plain(FUNC_UNUSED);
		send_plain(FUNC_START);
		repeat (5) send_plain(FUNC_TICK);
		settle();
		// clock now beyond a shortened duration
		set_fade(16'd1, 1'b0, 16'd0);
		send_plain(FUNC_TICK);
		settle();

		// random phases: fixed extremes first, then random settings
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: set_fade(16'd0, 1'b0, 16'd0);
				1: set_fade(16'hFFFF, 1'b1, 16'd0);
				2: set_fade(16'hFFFF, 1'b1, 16'hFFFF);
				3: set_fade(16'd3, 1'b1, 16'd2);
				default: begin
					dur = ($urandom_range(7) == 0) ? int'(DUR_W'($urandom)) : $urandom_range(12);
					early = ($urandom_range(2) == 0);
					stop = ($urandom_range(5) == 0) ? 16'hFFFF : $urandom_range(dur + 2);
					set_fade(DUR_W'(dur), early, DUR_W'(stop));
				end
			endcase
			calm = (p == 4);
			for (n = 0; n < WORDS_PER_PHASE; n++) begin
				// long receiver hold-off while input words keep coming
				if (p == 2 && n == 3)
					hold_req = 1'b1;
				pick = $urandom_range(99);
				if (n == 0 && $urandom_range(3) != 0)
					send_plain(FUNC_START);
				else if (pick < 25)
					send_word(FUNC_LOAD, IDX_W'($urandom), pick_color(), pick_color());
				else if (pick < 35)
					send_plain(FUNC_START);
				else if (pick < 40)
					send_plain(FUNC_UNUSED);
				else
					send_plain(FUNC_TICK);
			end
			settle();
		end
		calm = 1'b0;

		$display("covered %0d input words: %0d color ticks, %0d done ticks, %0d hold-offs",
			board.words_in, board.color_ticks, board.done_ticks, holds_done);
		$display("checked %0d result words, %0d mismatches", board.words_checked, board.errors);
		if (board.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
